// File: src/daeo_pkg.sv
// Shared types and constants for the dual absolute encoder odometry block.
// No dependencies; daeo_lane and dual_absolute_encoder_odometry import this package.
`default_nettype none

package daeo_pkg;

    // Fixed field widths of the item and result ports
    localparam int CODE_W = 12;
    localparam int US_W   = 20;
    localparam int VEL_W  = 33;
    localparam int ODO_W  = 32;

    // Velocity numerator after dropping the code scaling; fits below 2^32
    localparam int DIV_NUM_W = 32;

    // 2*pi*1e9, rounded
    localparam logic [32:0] VEL_SCALE = 33'd6283185307;
    // 2*pi*1000*2^32, rounded
    localparam int ODO_SCALE_W = 45;
    localparam logic [ODO_SCALE_W-1:0] ODO_SCALE = 45'd26986075409044;
    // Velocity saturation magnitude in mrad/s
    localparam logic [DIV_NUM_W-1:0] VEL_LIMIT = 32'd3141593000;

    // Per-item command from the top level to each lane
    typedef struct packed {
        logic start;   // new sample for this lane
        logic update;  // compute velocity and odometry, else load angle and clear velocity
    } daeo_lane_ctl_t;

endpackage

`default_nettype wire

// File: src/daeo_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters; used by daeo_lane.
`default_nettype none

module daeo_divider #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // Shift the next numerator bit into the partial remainder
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg  <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else if (start)
        begin
            quot_reg  <= num;
            rem_reg   <= '0;
            den_reg   <= den;
            count_reg <= CNT_W'(NUM_W);
            busy_reg  <= 1'b1;
        end
        else if (busy_reg)
        begin
            quot_reg  <= {quot_reg[NUM_W-2:0], fits};
            rem_reg   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// File: src/daeo_lane.sv
// One encoder channel: wrapped angle change, velocity through a shared-width
// divider, and the fixed-point odometer. Depends on daeo_pkg and daeo_divider.
`default_nettype none

module daeo_lane #(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire daeo_pkg::daeo_lane_ctl_t      ctl,
    input  wire logic [daeo_pkg::CODE_W-1:0]   code,
    input  wire logic [daeo_pkg::US_W-1:0]     elapsed_us,
    output logic                               busy,
    output logic [daeo_pkg::CODE_W-1:0]        angle,
    output logic signed [daeo_pkg::VEL_W-1:0]  velocity,
    output logic signed [daeo_pkg::ODO_W-1:0]  odometer
);

    import daeo_pkg::*;

    localparam int EXT_W  = (ADC_BITS > CODE_W) ? ADC_BITS : CODE_W;
    localparam int VP_W   = ADC_BITS + 33;
    localparam int OP_W   = ADC_BITS + ODO_SCALE_W;
    localparam int SHIFT  = 32 + ADC_BITS - FRAC_BITS;
    localparam int DLT_W  = OP_W - SHIFT;
    localparam int CAR_W  = FRAC_BITS + 15;
    localparam int WHL_W  = CAR_W - 1 - FRAC_BITS;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_ACC,
        L_DIV
    } lane_state_t;

    lane_state_t                 state_reg;
    logic [ADC_BITS-1:0]         prev_reg;
    logic                        neg_reg;
    logic [ADC_BITS-1:0]         mag_reg;
    logic [VP_W-1:0]             vprod_reg;
    logic [DLT_W-1:0]            delta_reg;
    logic signed [FRAC_BITS:0]   frac_reg;
    logic [ODO_W-1:0]            total_reg;
    logic signed [VEL_W-1:0]     vel_reg;

    logic [EXT_W-1:0]            code_ext;
    logic [ADC_BITS-1:0]         code_a;
    logic [ADC_BITS-1:0]         gap;
    logic [ADC_BITS-1:0]         gap_mag;
    logic [VP_W-1:0]             vprod;
    logic [OP_W-1:0]             oprod;

    logic signed [CAR_W-1:0]     carry;
    logic [CAR_W-1:0]            carry_mag;
    logic [WHL_W-1:0]            whole;
    logic [FRAC_BITS:0]          rem_ext;
    logic [ODO_W-1:0]            total_next;
    logic signed [FRAC_BITS:0]   frac_next;

    logic                        div_start;
    logic                        div_busy;
    logic [DIV_NUM_W-1:0]        div_quot;
    logic [DIV_NUM_W-1:0]        vel_sat;
    logic [VEL_W-1:0]            vel_mag;
    logic signed [VEL_W-1:0]     vel_next;

    // Drop code bits above ADC_BITS
    assign code_ext = EXT_W'(code);
    assign code_a   = code_ext[ADC_BITS-1:0];

    // Two's complement wrap gives the half-turn window; exactly half counts negative
    assign gap     = code_a - prev_reg;
    assign gap_mag = gap[ADC_BITS-1] ? (~gap + 1'b1) : gap;

    assign vprod = {{33{1'b0}}, mag_reg} * {{ADC_BITS{1'b0}}, VEL_SCALE};
    assign oprod = {{ODO_SCALE_W{1'b0}}, mag_reg} * {{ADC_BITS{1'b0}}, ODO_SCALE};

    // Odometer carry: signed fraction plus signed delta, split toward zero
    always_comb
    begin
        carry = CAR_W'(frac_reg);
        if (neg_reg)
        begin
            carry = carry - $signed(CAR_W'(delta_reg));
        end
        else
        begin
            carry = carry + $signed(CAR_W'(delta_reg));
        end
        carry_mag = carry[CAR_W-1] ? (~carry + 1'b1) : carry;
        whole     = carry_mag[CAR_W-2:FRAC_BITS];
        rem_ext   = {1'b0, carry_mag[FRAC_BITS-1:0]};
        if (carry[CAR_W-1])
        begin
            total_next = total_reg - ODO_W'(whole);
            frac_next  = $signed(~rem_ext + 1'b1);
        end
        else
        begin
            total_next = total_reg + ODO_W'(whole);
            frac_next  = $signed(rem_ext);
        end
    end

    // Quotient of (mag*scale >> ADC_BITS) by elapsed time equals the full quotient
    assign div_start = (state_reg == L_ACC);

    daeo_divider #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (US_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (vprod_reg[ADC_BITS+DIV_NUM_W-1:ADC_BITS]),
        .den   (elapsed_us),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign vel_sat  = (div_quot > VEL_LIMIT) ? VEL_LIMIT : div_quot;
    assign vel_mag  = {1'b0, vel_sat};
    assign vel_next = neg_reg ? $signed(~vel_mag + 1'b1) : $signed(vel_mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            prev_reg  <= '0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            vprod_reg <= '0;
            delta_reg <= '0;
            frac_reg  <= '0;
            total_reg <= '0;
            vel_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                L_IDLE:
                begin
                    if (ctl.start)
                    begin
                        prev_reg <= code_a;
                        if (ctl.update)
                        begin
                            neg_reg   <= gap[ADC_BITS-1];
                            mag_reg   <= gap_mag;
                            state_reg <= L_MUL;
                        end
                        else
                        begin
                            vel_reg <= '0;
                        end
                    end
                end
                L_MUL:
                begin
                    vprod_reg <= vprod;
                    delta_reg <= oprod[OP_W-1:SHIFT];
                    state_reg <= L_ACC;
                end
                L_ACC:
                begin
                    total_reg <= total_next;
                    frac_reg  <= frac_next;
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    if (!div_busy)
                    begin
                        vel_reg   <= vel_next;
                        state_reg <= L_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != L_IDLE);
    assign angle    = CODE_W'(prev_reg);
    assign velocity = vel_reg;
    assign odometer = $signed(total_reg);

endmodule

`default_nettype wire

// File: src/dual_absolute_encoder_odometry.sv
// Dual absolute encoder odometry: two parallel channel lanes plus the result
// register that merges their outputs. Depends on daeo_pkg and daeo_lane.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one ADC code per encoder and the
//   microseconds since the previous sample. Output channel (out_valid/out_ready)
//   carries both angles, velocities in mrad/s and wrapping odometers in mrad.
//   The first transfer after reset only loads the angles and returns a result
//   with zero velocity and unchanged odometers.
//   Later transfers with elapsed_us of zero are dropped with no result.
//   Every other transfer passes through a multiply step, an accumulate step,
//   the bit-serial velocity divider, which both lanes run side by side, a step
//   to take the quotient and the load of the result register. in_ready stays
//   low until the result register is loaded, so no new sample enters while
//   one is still in the lanes.
//   in_ready is high whenever the block is idle, even while a result waits in
//   the output register; a stalled receiver holds the finished lanes until the
//   output register frees up, and input stops in that time.
//   Reset (rst_n low, asynchronous) clears the angles, fractions, odometers and
//   the primed flag and empties the output register.
`default_nettype none

module dual_absolute_encoder_odometry #(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [daeo_pkg::CODE_W-1:0]   left_code,
    input  wire logic [daeo_pkg::CODE_W-1:0]   right_code,
    input  wire logic [daeo_pkg::US_W-1:0]     elapsed_us,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [daeo_pkg::CODE_W-1:0]        left_angle,
    output logic [daeo_pkg::CODE_W-1:0]        right_angle,
    output logic signed [daeo_pkg::VEL_W-1:0]  left_velocity,
    output logic signed [daeo_pkg::VEL_W-1:0]  right_velocity,
    output logic signed [daeo_pkg::ODO_W-1:0]  left_odometer,
    output logic signed [daeo_pkg::ODO_W-1:0]  right_odometer
);

    import daeo_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } top_state_t;

    top_state_t              state_reg;
    logic                    primed_reg;
    logic [US_W-1:0]         us_reg;
    logic                    out_valid_reg;
    logic [CODE_W-1:0]       left_angle_reg;
    logic [CODE_W-1:0]       right_angle_reg;
    logic signed [VEL_W-1:0] left_vel_reg;
    logic signed [VEL_W-1:0] right_vel_reg;
    logic signed [ODO_W-1:0] left_odo_reg;
    logic signed [ODO_W-1:0] right_odo_reg;

    logic                    accept;
    logic                    take;
    logic                    out_free;
    logic                    load_result;
    daeo_lane_ctl_t          lane_ctl;

    logic                    left_busy;
    logic                    right_busy;
    logic [CODE_W-1:0]       left_lane_angle;
    logic [CODE_W-1:0]       right_lane_angle;
    logic signed [VEL_W-1:0] left_lane_vel;
    logic signed [VEL_W-1:0] right_lane_vel;
    logic signed [ODO_W-1:0] left_lane_odo;
    logic signed [ODO_W-1:0] right_lane_odo;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    // Once primed, drop transfers with no elapsed time
    assign take     = accept && (!primed_reg || (elapsed_us != '0));
    assign out_free = !out_valid_reg || out_ready;
    assign load_result = (state_reg == ST_BUSY) && !left_busy && !right_busy && out_free;

    assign lane_ctl.start  = take;
    assign lane_ctl.update = primed_reg;

    daeo_lane #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (lane_ctl),
        .code       (left_code),
        .elapsed_us (us_reg),
        .busy       (left_busy),
        .angle      (left_lane_angle),
        .velocity   (left_lane_vel),
        .odometer   (left_lane_odo)
    );

    daeo_lane #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (lane_ctl),
        .code       (right_code),
        .elapsed_us (us_reg),
        .busy       (right_busy),
        .angle      (right_lane_angle),
        .velocity   (right_lane_vel),
        .odometer   (right_lane_odo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            primed_reg      <= 1'b0;
            us_reg          <= '0;
            out_valid_reg   <= 1'b0;
            left_angle_reg  <= '0;
            right_angle_reg <= '0;
            left_vel_reg    <= '0;
            right_vel_reg   <= '0;
            left_odo_reg    <= '0;
            right_odo_reg   <= '0;
        end
        else
        begin
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        us_reg     <= elapsed_us;
                        primed_reg <= 1'b1;
                        state_reg  <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    // Merge both lanes into the result register once it is free
                    if (load_result)
                    begin
                        left_angle_reg  <= left_lane_angle;
                        right_angle_reg <= right_lane_angle;
                        left_vel_reg    <= left_lane_vel;
                        right_vel_reg   <= right_lane_vel;
                        left_odo_reg    <= left_lane_odo;
                        right_odo_reg   <= right_lane_odo;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_angle     = left_angle_reg;
    assign right_angle    = right_angle_reg;
    assign left_velocity  = left_vel_reg;
    assign right_velocity = right_vel_reg;
    assign left_odometer  = left_odo_reg;
    assign right_odometer = right_odo_reg;

    // Both lanes run the same schedule
    a_lanes_lockstep: assert property (
        @(posedge clk) disable iff (!rst_n)
        left_busy == right_busy
    ) else $error("lanes out of step");

    // No input transfer while a lane is still working
    a_accept_idle_lanes: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> (!left_busy && !right_busy)
    ) else $error("input transfer during lane work");

    // A result exists only after the first sample has primed the block
    a_result_primed: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> primed_reg
    ) else $error("result before first sample");

    // A new result appears only out of the busy state
    a_result_from_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_BUSY)
    ) else $error("result loaded outside busy state");

endmodule

`default_nettype wire

// File: tb/dual_absolute_encoder_odometry_tb.sv
// Testbench for dual_absolute_encoder_odometry: random and directed encoder samples,
// an in-bench angle/velocity/odometer predictor, and field-by-field result checks.
// Depends on daeo_pkg and the dual_absolute_encoder_odometry RTL.
`timescale 1ns / 1ps

module dual_absolute_encoder_odometry_tb;

    import daeo_pkg::*;

    localparam longint unsigned RATE_K     = 64'd6283185307;     // 2*pi*1e9
    localparam longint unsigned ODO_K      = 64'd26986075409044; // 2*pi*1000*2^32
    localparam longint unsigned RATE_CAP   = 64'd3141593000;
    localparam int              ODO_SHIFT  = 28;                 // 32 + 12 - 16
    localparam int              FRAC_SHIFT = 16;
    localparam int              TURN       = 4096;
    localparam int              HALF       = 2048;

    typedef struct packed {
        logic [CODE_W-1:0] lc;
        logic [CODE_W-1:0] rc;
        logic [US_W-1:0]   us;
    } sample_t;

    typedef struct packed {
        logic [CODE_W-1:0] l_ang;
        logic [CODE_W-1:0] r_ang;
        logic [VEL_W-1:0]  l_vel;
        logic [VEL_W-1:0]  r_vel;
        logic [ODO_W-1:0]  l_odo;
        logic [ODO_W-1:0]  r_odo;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CODE_W-1:0] left_code = '0;
    logic [CODE_W-1:0] right_code = '0;
    logic [US_W-1:0] elapsed_us = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CODE_W-1:0] left_angle;
    logic [CODE_W-1:0] right_angle;
    logic signed [VEL_W-1:0] left_velocity;
    logic signed [VEL_W-1:0] right_velocity;
    logic signed [ODO_W-1:0] left_odometer;
    logic signed [ODO_W-1:0] right_odometer;

    dual_absolute_encoder_odometry dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_code      (left_code),
        .right_code     (right_code),
        .elapsed_us     (elapsed_us),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_angle     (left_angle),
        .right_angle    (right_angle),
        .left_velocity  (left_velocity),
        .right_velocity (right_velocity),
        .left_odometer  (left_odometer),
        .right_odometer (right_odometer)
    );

    sample_t  sample_queue[$];
    reading_t pending_readings[$];

    // predictor state
    bit              primed = 1'b0;
    bit [CODE_W-1:0] last_code[2] = '{default: '0};
    longint          frac[2] = '{default: 0};
    bit [ODO_W-1:0]  odo[2] = '{default: '0};

    bit              calm = 1'b0;
    int              fail_count = 0;
    int              idle_left = 0;
    int              stall_left = 0;
    int              hold_off = 0;
    int              results_seen = 0;
    bit [CODE_W-1:0] drift_l = '0;
    bit [CODE_W-1:0] drift_r = '0;
    sample_t         next_sample;
    reading_t        want;
    reading_t        fresh;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Signed code change, wrapped to half a turn; exactly half counts negative.
    function automatic int code_step(input bit [CODE_W-1:0] now, input bit [CODE_W-1:0] was);
        bit [CODE_W-1:0] raw;
        int d;
        raw = now - was;
        d = int'(raw);
        if (d >= HALF)
            d -= TURN;
        return d;
    endfunction

    function automatic bit [VEL_W-1:0] rate_mrad(input int d, input bit [US_W-1:0] us);
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        bit [VEL_W-1:0] v;
        mag = 64'((d < 0) ? -d : d);
        den = 64'(us);
        den = den << 12;
        q = (mag * RATE_K) / den;
        if (q > RATE_CAP)
            q = RATE_CAP;
        v = q[VEL_W-1:0];
        if (d < 0)
            v = -v;
        return v;
    endfunction

    // Add the change to the odometer; keep the sub-mrad part, truncated toward zero.
    function automatic void advance_odo(input int ch, input int d);
        longint unsigned mag;
        longint unsigned cm;
        longint unsigned whole;
        longint sdelta;
        longint carry;
        mag = 64'((d < 0) ? -d : d);
        sdelta = (mag * ODO_K) >> ODO_SHIFT;
        if (d < 0)
            sdelta = -sdelta;
        carry = frac[ch] + sdelta;
        if (carry < 0)
            cm = -carry;
        else
            cm = carry;
        whole = cm >> FRAC_SHIFT;
        if (carry < 0)
        begin
            odo[ch] = odo[ch] - whole[ODO_W-1:0];
            frac[ch] = -longint'(cm & 64'hFFFF);
        end
        else
        begin
            odo[ch] = odo[ch] + whole[ODO_W-1:0];
            frac[ch] = longint'(cm & 64'hFFFF);
        end
    endfunction

    function automatic bit predict_reading(input sample_t s, output reading_t r);
        int dl;
        int dr;
        r.l_ang = s.lc;
        r.r_ang = s.rc;
        r.l_vel = '0;
        r.r_vel = '0;
        if (primed)
        begin
            // drop zero-time samples once primed
            if (s.us == 0)
                return 1'b0;
            dl = code_step(s.lc, last_code[0]);
            dr = code_step(s.rc, last_code[1]);
            r.l_vel = rate_mrad(dl, s.us);
            r.r_vel = rate_mrad(dr, s.us);
            advance_odo(0, dl);
            advance_odo(1, dr);
        end
        primed = 1'b1;
        last_code[0] = s.lc;
        last_code[1] = s.rc;
        r.l_odo = odo[0];
        r.r_odo = odo[1];
        return 1'b1;
    endfunction

    function automatic void check_field(input string tag, input logic [VEL_W-1:0] exp_v,
                                        input logic [VEL_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, exp_v, act_v);
        end
    endfunction

    // Input driver: hold the payload until the transfer, then pop the next sample.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (predict_reading({left_code, right_code, elapsed_us}, fresh))
                    pending_readings.push_back(fresh);
            end
            if (in_valid && !in_ready)
            begin
                // hold
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (sample_queue.size() > 0)
            begin
                next_sample = sample_queue.pop_front();
                in_valid <= 1'b1;
                left_code <= next_sample.lc;
                right_code <= next_sample.rc;
                elapsed_us <= next_sample.us;
                if (!calm && $urandom_range(0, 9) == 0)
                    idle_left = $urandom_range(1, 13);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random stalls and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual angles %h %h",
                             $time, left_angle, right_angle);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("left_angle", $unsigned(want.l_ang), $unsigned(left_angle));
                    check_field("right_angle", $unsigned(want.r_ang), $unsigned(right_angle));
                    check_field("left_velocity", want.l_vel, $unsigned(left_velocity));
                    check_field("right_velocity", want.r_vel, $unsigned(right_velocity));
                    check_field("left_odometer", $unsigned(want.l_odo),
                                $unsigned(left_odometer));
                    check_field("right_odometer", $unsigned(want.r_odo),
                                $unsigned(right_odometer));
                end
                results_seen++;
                // back up the block while the sender keeps offering
                if (results_seen == 200)
                    hold_off = 400;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    task automatic push_sample(input int lc, input int rc, input int us);
        sample_t s;
        s.lc = lc[CODE_W-1:0];
        s.rc = rc[CODE_W-1:0];
        s.us = us[US_W-1:0];
        sample_queue.push_back(s);
    endtask

    // Mostly smooth motion, some half-turn jumps, some noise and zero-time samples.
    task automatic queue_random(input int count);
        sample_t s;
        int pick;
        int step;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                drift_l = CODE_W'($urandom);
                drift_r = CODE_W'($urandom);
            end
            else if (pick < 20)
            begin
                step = $urandom_range(2040, 2056);
                drift_l = drift_l + step[CODE_W-1:0];
                step = $urandom_range(2040, 2056);
                drift_r = drift_r + step[CODE_W-1:0];
            end
            else
            begin
                step = $urandom_range(0, 120) - 60;
                drift_l = drift_l + step[CODE_W-1:0];
                step = $urandom_range(0, 120) - 60;
                drift_r = drift_r + step[CODE_W-1:0];
            end
            s.lc = drift_l;
            s.rc = drift_r;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                s.us = '0;
            else if (pick < 40)
                s.us = US_W'($urandom_range(1, 300));
            else if (pick < 70)
                s.us = US_W'($urandom_range(1, 20000));
            else
                s.us = US_W'($urandom_range(1, 20'hFFFFF));
            sample_queue.push_back(s);
        end
    endtask

    task automatic wait_quiet();
        while (sample_queue.size() != 0 || in_valid || pending_readings.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample primes even with zero time
        push_sample(4095, 0, 0);
        push_sample(100, 100, 0);
        // wrap across zero both ways, shortest time
        push_sample(0, 4095, 1);
        // exactly half a turn on both, longest time
        push_sample(2048, 2047, 20'hFFFFF);
        push_sample(0, 0, 1);
        push_sample(2047, 2049, 1);
        push_sample(2047, 2049, 1000);
        push_sample(2048, 2048, 3);
        push_sample(2049, 2047, 7);
        push_sample(2048, 2048, 0);
        push_sample(2050, 2046, 20'h80000);
        push_sample(2051, 2045, 20'h7FFFF);
        push_sample(2052, 2044, 20'h55555);
        push_sample(2053, 2043, 20'hAAAAA);
        push_sample(4095, 4095, 1);
        push_sample(0, 0, 2);
        push_sample(2048, 0, 5);
        push_sample(4095, 2048, 20'h00FFF);
        push_sample(1, 4095, 20'hFF000);
        wait_quiet();

        queue_random(600);
        while (sample_queue.size() != 0)
            @(posedge clk);
        queue_random(380);
        while (sample_queue.size() != 0)
            @(posedge clk);
        calm = 1'b1;
        queue_random(150);
        wait_quiet();
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
src/daeo_pkg.sv
src/daeo_divider.sv
src/daeo_lane.sv
src/dual_absolute_encoder_odometry.sv
tb/dual_absolute_encoder_odometry_tb.sv
